[rtl/mta_pkg.sv]
// Shared types and codes for the membership table.
// No dependencies; imported by mta_mem and the top level.
package mta_pkg;

    localparam int KEY_W = 31;
    localparam int OP_W  = 2;
    localparam int ANS_W = 2;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [OP_W-1:0]  op_t;
    typedef logic [ANS_W-1:0] ans_t;

    // request opcodes (code 3 is ignored)
    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_QUERY  = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;

    // answer codes
    localparam ans_t ANS_ADDED   = 2'd0;
    localparam ans_t ANS_EXISTS  = 2'd1;
    localparam ans_t ANS_FULL    = 2'd2;
    localparam ans_t ANS_ABSENT  = 2'd0;
    localparam ans_t ANS_PRESENT = 2'd1;

endpackage

[rtl/membership_table_add_query_remove_top.sv]
// Membership table: bounded set of unique 31-bit keys with add, query and remove.
// Depends on mta_pkg and mta_mem.
//
// A request (op, key) is taken when start is high and busy is low. Keys live
// packed in a single-port-read memory; one comparator walks the list one entry
// per cycle, and add and query stop early on a hit, as soon as the matching
// entry's read data is compared. An add to a full table answers straight from
// idle without a scan. A remove scans to the match and then moves each later
// entry down one slot per cycle through the same read port; it gives no answer.
// Op code 3 is dropped. Answers appear on answer for exactly one cycle with done
// high; the receiver cannot hold them off, and a new request may be issued in
// that same cycle.
module membership_table_add_query_remove_top #(
    parameter int DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mta_pkg::op_t  op,
    input  mta_pkg::key_t key,
    output logic          done,
    output mta_pkg::ans_t answer
);
    import mta_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT} state_t;

    state_t          state_reg;
    op_t             op_reg;
    key_t            key_reg;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   ptr_reg;      // next entry to read
    logic            cmp_vld_reg;  // read data is valid this cycle
    logic [AW-1:0]   cmp_idx_reg;  // entry the read data came from
    logic            done_reg;
    ans_t            answer_reg;

    logic            issue;
    logic            hit;
    logic            at_end;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    key_t            mem_wdata;
    key_t            mem_rdata;

    // shared read port and comparator
    assign issue  = (state_reg != ST_IDLE) && (ptr_reg != fill_reg);
    assign hit    = cmp_vld_reg && (mem_rdata == key_reg);
    assign at_end = (ptr_reg == fill_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = fill_reg[AW-1:0];
        mem_wdata = key_reg;
        if (state_reg == ST_SHIFT)
        begin
            // move entry idx down to idx-1
            mem_we    = cmp_vld_reg;
            mem_waddr = cmp_idx_reg - AW'(1);
            mem_wdata = mem_rdata;
        end
        else if (state_reg == ST_SCAN)
        begin
            // append on a miss
            mem_we = !hit && at_end && (op_reg == OP_ADD);
        end
    end

    mta_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            ptr_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            done_reg    <= 1'b0;
            answer_reg  <= ANS_ADDED;
            op_reg      <= OP_ADD;
            key_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg      <= op;
                        key_reg     <= key;
                        ptr_reg     <= '0;
                        cmp_vld_reg <= 1'b0;
                        if (op == OP_ADD && fill_reg == CW'(DEPTH))
                        begin
                            answer_reg <= ANS_FULL;
                            done_reg   <= 1'b1;
                        end
                        else if (op == OP_ADD || op == OP_QUERY || op == OP_REMOVE)
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    ptr_reg     <= ptr_reg + CW'(issue);
                    cmp_vld_reg <= issue;
                    cmp_idx_reg <= ptr_reg[AW-1:0];
                    if (hit)
                    begin
                        unique case (op_reg)
                            OP_ADD:
                            begin
                                answer_reg <= ANS_EXISTS;
                                done_reg   <= 1'b1;
                                state_reg  <= ST_IDLE;
                            end
                            OP_QUERY:
                            begin
                                answer_reg <= ANS_PRESENT;
                                done_reg   <= 1'b1;
                                state_reg  <= ST_IDLE;
                            end
                            OP_REMOVE:
                            begin
                                ptr_reg     <= CW'(cmp_idx_reg) + CW'(1);
                                cmp_vld_reg <= 1'b0;
                                state_reg   <= ST_SHIFT;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                    else if (at_end)
                    begin
                        if (op_reg == OP_ADD)
                        begin
                            fill_reg   <= fill_reg + CW'(1);
                            answer_reg <= ANS_ADDED;
                            done_reg   <= 1'b1;
                        end
                        else if (op_reg == OP_QUERY)
                        begin
                            answer_reg <= ANS_ABSENT;
                            done_reg   <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SHIFT:
                begin
                    ptr_reg     <= ptr_reg + CW'(issue);
                    cmp_vld_reg <= issue;
                    cmp_idx_reg <= ptr_reg[AW-1:0];
                    if (at_end)
                    begin
                        // last move (if any) is written this cycle
                        fill_reg  <= fill_reg - CW'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign answer = answer_reg;

    // an answer only follows a request that was taken or in progress
    a_done_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("answer without a request");

    // answers are issued on the way back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("answer while busy");

    // fill count never passes capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count over capacity");

    // writes stay within the occupied list (append slot included)
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_waddr) < fill_reg || CW'(mem_waddr) == fill_reg))
        else $error("write beyond list");

endmodule

[rtl/mta_mem.sv]
// Key storage: one write port, one read port with registered read data.
// Depends on mta_pkg for the key type.
module mta_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  mta_pkg::key_t     wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output mta_pkg::key_t     rdata
);
    import mta_pkg::*;

    key_t mem [DEPTH];
    key_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[dv/membership_table_add_query_remove_top_test.sv]
// Testbench for membership_table_add_query_remove_top: directed table, then random traffic.
// Depends on rtl/mta_pkg.sv and the RTL of the block; scoreboard holds its own key-list model.
module membership_table_add_query_remove_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mta_pkg::*;

    localparam int DEPTH       = 128;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PHASE_ITEMS = 250;
    // drain allowance after the last request: a remove can walk the whole list
    localparam int DRAIN_CYCLES = DEPTH + 8;

    // op code 3 is dropped by the block
    localparam op_t OP_UNUSED = 2'd3;
    localparam key_t KEY_MAX  = 31'h7FFF_FFFF;

    // one directed stimulus row; typed rows carry the answer read straight off the spec
    typedef struct {
        op_t  op;
        key_t key;
        bit   typed;
        ans_t ans;
    } stim_row_t;

    // an answer still owed by the block, with the request that caused it
    typedef struct {
        ans_t ans;
        op_t  op;
        key_t key;
    } owed_answer_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    op_t  op;
    key_t key;
    logic done;
    ans_t answer;

    // scoreboard copy of the registry
    key_t        registry_keys [DEPTH];
    int unsigned registry_fill;

    owed_answer_t answers_owed [$];
    int unsigned  error_count;
    int unsigned  sender_idle_pct;

    // side channel from the driver to the scoreboard for typed table rows
    bit   row_typed;
    ans_t row_answer;

    // Directed part. Covers empty list, both key extremes, duplicate add, remove of
    // a head entry (compaction), remove of a key that is not listed, the unused op
    // code, and a query of key 0 once the slot it lived in has been vacated.
    stim_row_t directed_rows [0:24] = '{
        '{OP_QUERY,  31'h0,         1'b1, ANS_ABSENT},
        '{OP_QUERY,  KEY_MAX,       1'b1, ANS_ABSENT},
        '{OP_REMOVE, 31'h5,         1'b0, ANS_ADDED},
        '{OP_UNUSED, KEY_MAX,       1'b0, ANS_ADDED},
        '{OP_ADD,    31'h0,         1'b1, ANS_ADDED},
        '{OP_ADD,    KEY_MAX,       1'b1, ANS_ADDED},
        '{OP_ADD,    31'h0,         1'b1, ANS_EXISTS},
        '{OP_QUERY,  31'h0,         1'b1, ANS_PRESENT},
        '{OP_QUERY,  KEY_MAX,       1'b1, ANS_PRESENT},
        '{OP_ADD,    31'h5555_5555, 1'b0, ANS_ADDED},
        '{OP_ADD,    31'h2AAA_AAAA, 1'b0, ANS_ADDED},
        '{OP_REMOVE, 31'h0,         1'b0, ANS_ADDED},
        '{OP_QUERY,  31'h0,         1'b0, ANS_ADDED},
        '{OP_REMOVE, KEY_MAX,       1'b0, ANS_ADDED},
        '{OP_REMOVE, 31'h1_2345,    1'b0, ANS_ADDED},
        '{OP_UNUSED, 31'h5555_5555, 1'b0, ANS_ADDED},
        '{OP_QUERY,  31'h5555_5555, 1'b0, ANS_ADDED},
        '{OP_QUERY,  31'h2AAA_AAAA, 1'b0, ANS_ADDED},
        '{OP_QUERY,  KEY_MAX,       1'b0, ANS_ADDED},
        '{OP_ADD,    KEY_MAX,       1'b0, ANS_ADDED},
        '{OP_QUERY,  31'h0,         1'b0, ANS_ADDED},
        '{OP_REMOVE, 31'h5555_5555, 1'b0, ANS_ADDED},
        '{OP_REMOVE, 31'h2AAA_AAAA, 1'b0, ANS_ADDED},
        '{OP_REMOVE, KEY_MAX,       1'b0, ANS_ADDED},
        '{OP_QUERY,  31'h0,         1'b0, ANS_ADDED}
    };

    membership_table_add_query_remove_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .op     (op),
        .key    (key),
        .done   (done),
        .answer (answer)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request to the registry model. Returns 1 when the block owes an
    // answer, with the answer in ans.
    function automatic bit registry_apply(input op_t o, input key_t k, output ans_t ans);
        int unsigned hit;
        int unsigned i;
        hit = registry_fill;
        for (i = 0; i < registry_fill; i++)
        begin
            if (hit == registry_fill && registry_keys[i] == k)
                hit = i;
        end
        ans = ANS_ADDED;
        case (o)
            OP_ADD:
            begin
                // full wins over exists
                if (registry_fill >= DEPTH)
                    ans = ANS_FULL;
                else if (hit < registry_fill)
                    ans = ANS_EXISTS;
                else
                begin
                    registry_keys[registry_fill] = k;
                    registry_fill++;
                    ans = ANS_ADDED;
                end
                return 1'b1;
            end
            OP_QUERY:
            begin
                ans = (hit < registry_fill) ? ANS_PRESENT : ANS_ABSENT;
                return 1'b1;
            end
            OP_REMOVE:
            begin
                // compact: later entries slide down one slot, top slot cleared
                if (hit < registry_fill)
                begin
                    for (i = hit; i + 1 < registry_fill; i++)
                        registry_keys[i] = registry_keys[i + 1];
                    registry_keys[registry_fill - 1] = '0;
                    registry_fill--;
                end
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Scoreboard. Everything is sampled at the rising edge, before the block's
    // flops update, so the pre-edge values of done/answer and start/busy are seen.
    // Answers are checked before the newly accepted request is modeled.
    always @(posedge clk)
    begin : scoreboard
        owed_answer_t head;
        ans_t         predicted;
        bit           gives_answer;
        if (rst_n)
        begin
            if (done)
            begin
                if (answers_owed.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected answer: expected none, actual %0d",
                             $time, answer);
                end
                else
                begin
                    head = answers_owed.pop_front();
                    if (answer !== head.ans)
                    begin
                        error_count++;
                        $display("%0t: answer mismatch (op %0d key 0x%08h): expected %0d, actual %0d",
                                 $time, head.op, head.key, head.ans, answer);
                    end
                end
            end
            if (start && !busy)
            begin
                gives_answer = registry_apply(op, key, predicted);
                if (gives_answer)
                    answers_owed.push_back('{row_typed ? row_answer : predicted, op, key});
            end
        end
    end

    // Drive one request: random idle cycles first, then hold start until the
    // block takes it. Inputs change only at the falling edge.
    task automatic issue_request(input op_t o, input key_t k, input bit typed, input ans_t ans);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start      <= 1'b1;
        op         <= o;
        key        <= k;
        row_typed  <= typed;
        row_answer <= ans;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold off until every owed answer is in and the block has gone quiet.
    task automatic hold_until_quiet();
        @(negedge clk);
        start <= 1'b0;
        while (answers_owed.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Key picker. hit_pct steers toward listed keys; the rest are one-bit
    // neighbors of listed keys, the extremes, or fully random keys.
    function automatic key_t pick_key(input int unsigned hit_pct);
        int unsigned roll;
        logic [31:0] raw;
        key_t        k;
        roll = $urandom_range(99);
        raw  = $urandom;
        k    = raw[30:0];
        if (registry_fill > 0 && roll < hit_pct)
            k = registry_keys[$urandom_range(registry_fill - 1)];
        else if (registry_fill > 0 && roll < hit_pct + 10)
            k = registry_keys[$urandom_range(registry_fill - 1)] ^ (key_t'(1) << $urandom_range(30));
        else if (roll < hit_pct + 14)
            k = ($urandom_range(1) != 0) ? KEY_MAX : key_t'(0);
        return k;
    endfunction

    // One random request. Below the target fill the mix leans on adds; at or
    // above it, removes lead the mix, ahead of adds and queries.
    task automatic random_request(input int unsigned target_fill);
        int unsigned roll;
        op_t         o;
        key_t        k;
        roll = $urandom_range(99);
        if (registry_fill < target_fill)
            o = (roll < 65) ? OP_ADD : (roll < 85) ? OP_QUERY :
                (roll < 97) ? OP_REMOVE : OP_UNUSED;
        else
            o = (roll < 30) ? OP_ADD : (roll < 55) ? OP_QUERY :
                (roll < 95) ? OP_REMOVE : OP_UNUSED;
        case (o)
            OP_ADD:    k = pick_key(25);
            OP_QUERY:  k = pick_key(50);
            OP_REMOVE: k = pick_key(75);
            default:   k = pick_key(30);
        endcase
        issue_request(o, k, 1'b0, ANS_ADDED);
    endtask

    // Watchdog.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("membership_table_add_query_remove_top_test: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned n;
        rst_n           = 1'b0;
        start           = 1'b0;
        op              = OP_ADD;
        key             = '0;
        row_typed       = 1'b0;
        row_answer      = ANS_ADDED;
        registry_fill   = 0;
        error_count     = 0;
        sender_idle_pct = 29;
        for (n = 0; n < DEPTH; n++)
            registry_keys[n] = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        for (n = 0; n < $size(directed_rows); n++)
            issue_request(directed_rows[n].op, directed_rows[n].key,
                          directed_rows[n].typed, directed_rows[n].ans);

        // phase 1: sender idles often-ish, fill the list up to capacity
        for (n = 0; n < PHASE_ITEMS; n++)
            random_request(DEPTH);

        // pause until everything owed has come back
        hold_until_quiet();

        // phase 2: sender idles most cycles, hover at the full boundary
        sender_idle_pct = 72;
        for (n = 0; n < PHASE_ITEMS; n++)
            random_request(DEPTH);

        hold_until_quiet();

        // phase 3: back-to-back, drain toward a quarter full
        sender_idle_pct = 0;
        for (n = 0; n < PHASE_ITEMS; n++)
            random_request(DEPTH / 4);

        // drain: last answers, then room for a trailing remove to finish
        @(negedge clk);
        start <= 1'b0;
        while (answers_owed.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("membership_table_add_query_remove_top_test: PASS");
        else
            $display("membership_table_add_query_remove_top_test: FAIL");
        $finish;
    end

endmodule

[membership_table_add_query_remove_top.f]
rtl/mta_pkg.sv
rtl/mta_mem.sv
rtl/membership_table_add_query_remove_top.sv
dv/membership_table_add_query_remove_top_test.sv
